// ===== rtl/core/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

  // Register widths
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned SETTLE_W = 20;
  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned WIDTH_W  = 32;   // echo width as fed to the multiplier

  // Parameter defaults
  localparam int unsigned TIME_WIDTH_DEF  = 32;
  localparam int unsigned COUNT_WIDTH_DEF = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd5;

  // Register reset values
  localparam logic                RST_MEDIAN_MODE = 1'b0;
  localparam logic [SCALE_W-1:0]  RST_SCALE       = 16'd557;
  localparam logic [OFFSET_W-1:0] RST_OFFSET      = 24'd93716;
  localparam logic [TICK_W-1:0]   RST_TRIG_LOW    = 8'd5;
  localparam logic [TICK_W-1:0]   RST_TRIG_HIGH   = 8'd10;
  localparam logic [SETTLE_W-1:0] RST_SETTLE      = 20'd100000;

  // Reading slots
  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;
  localparam logic [1:0] IDX_LAST   = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LOW,
    PH_HIGH,
    PH_SETTLE
  } phase_t;

  // Per-beat control that rides along the conversion pipeline
  typedef struct packed {
    logic       trig;
    logic       busy;
    logic       final_rd;   // last reading of the sequence: range is given
    logic       med;        // report median of three
    logic       conv;       // settle end: a reading is converted and stored
    logic [1:0] idx;        // reading slot
  } seq_ctl_t;

  typedef struct packed {
    seq_ctl_t           ctl;
    logic               big;    // echo width does not fit in WIDTH_W bits
    logic [WIDTH_W-1:0] w32;
  } seq_beat_t;

endpackage
`default_nettype wire

// ===== rtl/core/uer_seq.sv =====
// Echo edge capture, time base and trigger/settle sequencer.
`default_nettype none
module uer_seq #(
  parameter int unsigned TIME_WIDTH  = uer_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic                          start_req,
  input  wire logic                          echo_level,
  input  wire logic                          median_mode,
  input  wire logic [uer_pkg::TICK_W-1:0]    trig_low_ticks,
  input  wire logic [uer_pkg::TICK_W-1:0]    trig_high_ticks,
  input  wire logic [uer_pkg::SETTLE_W-1:0]  settle_ticks,
  output uer_pkg::seq_beat_t                 beat
);
  import uer_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > SETTLE_W) ? COUNT_WIDTH : SETTLE_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [TIME_WIDTH-1:0]  time_now_r, edge_start_r, echo_width_r;
  logic [TIME_WIDTH-1:0]  edge_start_nxt, echo_width_nxt;
  logic                   echo_prev_r;
  phase_t                 phase_r, phase_nxt, phase_cur;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_base, cnt_inc;
  logic [1:0]             idx_r, idx_nxt, idx_base, idx_c;
  logic [SETTLE_W-1:0]    len;
  logic [CMP_W-1:0]       cnt_ext, len_ext;
  logic                   done;
  logic                   big;
  logic [WIDTH_W-1:0]     w32;

  // Edge capture: a rising edge marks the start, a falling edge the width
  always_comb begin
    edge_start_nxt = edge_start_r;
    echo_width_nxt = echo_width_r;
    if (echo_level && !echo_prev_r) begin
      edge_start_nxt = time_now_r;
    end else if (!echo_level && echo_prev_r) begin
      echo_width_nxt = time_now_r - edge_start_r;
    end
  end

  generate
    if (TIME_WIDTH > WIDTH_W) begin : g_wide
      assign big = |echo_width_nxt[TIME_WIDTH-1:WIDTH_W];
      assign w32 = echo_width_nxt[WIDTH_W-1:0];
    end else begin : g_narrow
      assign big = 1'b0;
      assign w32 = WIDTH_W'(echo_width_nxt);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_now_r   <= '0;
      edge_start_r <= '0;
      echo_width_r <= '0;
      echo_prev_r  <= 1'b0;
    end else if (step_en) begin
      time_now_r   <= time_now_r + TIME_WIDTH'(1);
      edge_start_r <= edge_start_nxt;
      echo_width_r <= echo_width_nxt;
      echo_prev_r  <= echo_level;
    end
  end

  // Phase counter with saturation at the counter's top
  always_comb begin
    phase_cur = phase_r;
    cnt_base  = cnt_r;
    idx_base  = idx_r;
    if (phase_r == PH_IDLE && start_req) begin
      phase_cur = PH_LOW;
      cnt_base  = '0;
      idx_base  = IDX_FIRST;
    end
    cnt_inc = (cnt_base != CNT_MAX) ? cnt_base + COUNT_WIDTH'(1) : cnt_base;
    unique case (phase_cur)
      PH_LOW:    len = SETTLE_W'(trig_low_ticks);
      PH_HIGH:   len = SETTLE_W'(trig_high_ticks);
      PH_SETTLE: len = settle_ticks;
      default:   len = '0;
    endcase
    cnt_ext = CMP_W'(cnt_inc);
    len_ext = CMP_W'(len);
    done    = (cnt_ext >= len_ext) || (cnt_inc == CNT_MAX);
    idx_c   = (idx_base > IDX_LAST) ? IDX_LAST : idx_base;
  end

  always_comb begin
    phase_nxt = phase_cur;
    cnt_nxt   = cnt_base;
    idx_nxt   = idx_base;
    beat.ctl  = '0;
    beat.big  = big;
    beat.w32  = w32;
    beat.ctl.idx = idx_c;
    unique case (phase_cur)
      PH_LOW: begin
        beat.ctl.busy = 1'b1;
        cnt_nxt = cnt_inc;
        if (done) begin
          phase_nxt = PH_HIGH;
          cnt_nxt   = '0;
        end
      end
      PH_HIGH: begin
        beat.ctl.busy = 1'b1;
        beat.ctl.trig = 1'b1;
        cnt_nxt = cnt_inc;
        if (done) begin
          phase_nxt = PH_SETTLE;
          cnt_nxt   = '0;
        end
      end
      PH_SETTLE: begin
        beat.ctl.busy = 1'b1;
        cnt_nxt = cnt_inc;
        if (done) begin
          beat.ctl.conv = 1'b1;
          cnt_nxt = '0;
          if (median_mode && idx_c < IDX_LAST) begin
            idx_nxt   = idx_c + 2'd1;
            phase_nxt = PH_LOW;
          end else begin
            beat.ctl.final_rd = 1'b1;
            beat.ctl.med      = median_mode;
            idx_nxt   = IDX_FIRST;
            phase_nxt = PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      idx_r   <= IDX_FIRST;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers and conversion pipeline.
//
// One input beat is one timer tick (start request and sampled echo level) and
// gives exactly one output beat (trigger level, busy, range valid, range).
// A new beat is taken every cycle unless out_tready stalls; each beat goes
// through the sequencer, 32x16 multiply and offset/saturate/median stages, the
// last feeding the output register. The multiply stage sets the clock budget. The
// trigger is held low for trig_low_ticks ticks (the start tick counts as the
// first), high for trig_high_ticks, then the block waits settle_ticks and
// converts the latest echo width as (width*scale_q16 + offset_q16) >> 16,
// saturated at 65535; in median mode it runs three times and gives the
// median. Write the config registers only while no beat is in flight.
`default_nettype none
module ultrasonic_echo_ranger #(
  parameter int unsigned TIME_WIDTH  = uer_pkg::TIME_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [0] start_req, [1] echo_level
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [23:0]                         out_tdata,  // [0] trig_level, [1] busy_res,
                                                          // [2] range_valid, [18:3] range_value
  input  wire logic                           cfg_we,
  input  wire logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uer_pkg::CFG_W-1:0]      cfg_wdata
);
  import uer_pkg::*;

  localparam int unsigned PROD_W = WIDTH_W + SCALE_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // Config registers
  logic                median_mode_r;
  logic [SCALE_W-1:0]  scale_r;
  logic [OFFSET_W-1:0] offset_r;
  logic [TICK_W-1:0]   trig_low_r, trig_high_r;
  logic [SETTLE_W-1:0] settle_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      median_mode_r <= RST_MEDIAN_MODE;
      scale_r       <= RST_SCALE;
      offset_r      <= RST_OFFSET;
      trig_low_r    <= RST_TRIG_LOW;
      trig_high_r   <= RST_TRIG_HIGH;
      settle_r      <= RST_SETTLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEDIAN_MODE: median_mode_r <= cfg_wdata[0];
        CFG_SCALE:       scale_r       <= cfg_wdata[SCALE_W-1:0];
        CFG_OFFSET:      offset_r      <= cfg_wdata[OFFSET_W-1:0];
        CFG_TRIG_LOW:    trig_low_r    <= cfg_wdata[TICK_W-1:0];
        CFG_TRIG_HIGH:   trig_high_r   <= cfg_wdata[TICK_W-1:0];
        CFG_SETTLE:      settle_r      <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic s2_ready, s3_ready, in_acc;

  assign s3_ready  = !out_v_r || out_tready;
  assign s2_ready  = !s2_v_r || s3_ready;
  assign in_tready = !s1_v_r || s2_ready;
  assign in_acc    = in_tvalid && in_tready;

  // Stage 1: sequencer
  seq_beat_t beat, s1_beat_r;

  uer_seq #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (in_acc),
    .start_req       (in_tdata[0]),
    .echo_level      (in_tdata[1]),
    .median_mode     (median_mode_r),
    .trig_low_ticks  (trig_low_r),
    .trig_high_ticks (trig_high_r),
    .settle_ticks    (settle_r),
    .beat            (beat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_beat_r <= beat;
    end
  end

  // Stage 2: multiply; an oversized width saturates unless the scale is zero
  seq_ctl_t            s2_ctl_r;
  logic [PROD_W-1:0]   prod_r;
  logic                sat_r;
  logic [WIDTH_W-1:0]  mul_a;

  assign mul_a = s1_beat_r.big ? '0 : s1_beat_r.w32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_ctl_r <= s1_beat_r.ctl;
      prod_r   <= PROD_W'(mul_a) * PROD_W'(scale_r);
      sat_r    <= s1_beat_r.big && (scale_r != '0);
    end
  end

  // Stage 3: offset, saturate, store the reading and take the median
  logic [SUM_W-1:0]   sum;
  logic [RANGE_W-1:0] rd_nxt, rd0_r, lo_r, hi_r, med_hi, med_val, value_nxt;
  logic               over;

  always_comb begin
    sum     = SUM_W'(prod_r) + SUM_W'(offset_r);
    over    = sat_r || (|sum[SUM_W-1:RANGE_W+16]);
    rd_nxt  = over ? {RANGE_W{1'b1}} : sum[RANGE_W+15:16];
    med_hi  = (hi_r < rd_nxt) ? hi_r : rd_nxt;
    med_val = (lo_r > med_hi) ? lo_r : med_hi;
    value_nxt = '0;
    if (s2_ctl_r.final_rd) begin
      value_nxt = s2_ctl_r.med ? med_val : rd_nxt;
    end
  end

  logic               trig_r, busy_r, valid_r;
  logic [RANGE_W-1:0] range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s3_ready) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s3_ready) begin
      trig_r  <= s2_ctl_r.trig;
      busy_r  <= s2_ctl_r.busy;
      valid_r <= s2_ctl_r.final_rd;
      range_r <= value_nxt;
      // Keep the first reading, then fold the second into a min/max pair
      if (s2_ctl_r.conv && s2_ctl_r.idx == IDX_FIRST) begin
        rd0_r <= rd_nxt;
      end
      if (s2_ctl_r.conv && s2_ctl_r.idx == IDX_SECOND) begin
        lo_r <= (rd0_r < rd_nxt) ? rd0_r : rd_nxt;
        hi_r <= (rd0_r < rd_nxt) ? rd_nxt : rd0_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'b0, range_r, valid_r, busy_r, trig_r};

endmodule
`default_nettype wire
